// ----- hw/rtl/rmq_pkg.sv -----
// Package for the rotation matrix to quaternion unit: widths, constants,
// stage payload types and the square root and division step functions.
// No dependencies.
package rmq_pkg;

  localparam int FRACTION_BITS = 14;
  localparam int IN_W          = 16;
  localparam int QW_W          = 15;
  localparam int Q_W           = 16;

  // Trace sum and its magnitude
  localparam int SUM_W  = IN_W + 4;
  localparam int ABS_W  = SUM_W - 1;
  localparam int DIAG_W = IN_W + 2;

  // Integer square root: 2*ROOT_W bit argument, one result bit per step
  localparam int ROOT_W      = 16;
  localparam int SQ_W        = 2 * ROOT_W;
  localparam int ROOT_STEPS  = ROOT_W;
  localparam int ROOT_STAGES = 4;
  localparam int ROOT_PER    = ROOT_STEPS / ROOT_STAGES;

  // Division: quotient bits 16..0, anything larger saturates
  localparam int DIFF_W     = IN_W + 1;
  localparam int DV_W       = QW_W + 2;
  localparam int QUO_W      = Q_W + 1;
  localparam int DIV_W      = DV_W + QUO_W;
  localparam int DIV_STEPS  = QUO_W;
  localparam int DIV_STAGES = 3;
  localparam int DIV_PER    = (DIV_STEPS + DIV_STAGES - 1) / DIV_STAGES;

  // Thresholds: 1000*w > 2^F and 10000*c > 2^F as integer minimums
  localparam int W_MIN    = (1 << FRACTION_BITS) / 1000 + 1;
  localparam int SIGN_MIN = (1 << FRACTION_BITS) / 10000 + 1;
  localparam int QPOS_MAX = 32767;
  localparam int QNEG_MAX = 32768;

  typedef struct packed {
    logic [SQ_W-1:0]   rem;
    logic [ROOT_W-1:0] root;
  } rmq_sq_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic signed [DIFF_W-1:0] dz;
    logic                     n01;
    logic                     n02;
    logic                     n12;
  } rmq_side_t;

  // lane 0: w, lanes 1..3: diagonal roots x, y, z
  typedef struct packed {
    rmq_sq_t [3:0] lane;
    rmq_side_t     side;
  } rmq_root_t;

  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [QUO_W-1:0] quo;
    logic             neg;
    logic             ovf;
  } rmq_dl_t;

  typedef struct packed {
    rmq_dl_t [2:0]   lane;
    logic [DV_W-1:0] dv;
    logic [QW_W-1:0] qw;
    logic [QW_W-1:0] dgx;
    logic [QW_W-1:0] dgy;
    logic [QW_W-1:0] dgz;
    logic            divp;
    logic            n01;
    logic            n02;
    logic            n12;
  } rmq_div_t;

  // One bit of the floor square root, bit position i
  function automatic rmq_sq_t sq_step(rmq_sq_t s, int i);
    logic [SQ_W-1:0] cand;
    rmq_sq_t         r;
    cand = (SQ_W'(s.root) << (i + 1)) | (SQ_W'(1) << (2 * i));
    r = s;
    if (s.rem >= cand) begin
      r.rem  = s.rem - cand;
      r.root = s.root | (ROOT_W'(1) << i);
    end
    return r;
  endfunction

  // One restoring division step, quotient bit i
  function automatic rmq_dl_t div_step(rmq_dl_t l, logic [DV_W-1:0] dv, int i);
    logic [DIV_W-1:0] cand;
    rmq_dl_t          r;
    cand = DIV_W'(dv) << i;
    r = l;
    if (l.rem >= cand) begin
      r.rem = l.rem - cand;
      r.quo = l.quo | (QUO_W'(1) << i);
    end
    return r;
  endfunction

  // Signed saturation of a divided component
  function automatic logic signed [Q_W-1:0] sat_quo(rmq_dl_t l);
    logic signed [Q_W-1:0] r;
    if (!l.neg) begin
      if (l.ovf || l.quo > QUO_W'(QPOS_MAX)) r = Q_W'(QPOS_MAX);
      else r = Q_W'(l.quo);
    end else begin
      if (l.ovf || l.quo > QUO_W'(QNEG_MAX)) r = Q_W'(QNEG_MAX);
      else r = -Q_W'(l.quo);
    end
    return r;
  endfunction

  function automatic logic signed [Q_W-1:0] apply_sign(logic [QW_W-1:0] mag, logic neg);
    logic signed [Q_W-1:0] r;
    r = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    return r;
  endfunction

endpackage

// ----- hw/rtl/rmq_if.sv -----
// Valid/ready channel interfaces for matrix input items and quaternion
// result items. Depends on rmq_pkg.
interface rmq_in_if;
  import rmq_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  input ready);
  modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  output ready);
endinterface

interface rmq_out_if;
  import rmq_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [QW_W-1:0]       qw;
  logic signed [Q_W-1:0] qx, qy, qz;
  modport source (output valid, qw, qx, qy, qz, input ready);
  modport sink   (input valid, qw, qx, qy, qz, output ready);
endinterface

// ----- hw/rtl/rotation_matrix_to_quaternion_unit.sv -----
// Rotation matrix to quaternion: front stage, square root pipe, path
// stage, divider pipe and output stage. Depends on rmq_pkg, rmq_if,
// rmq_root_pipe and rmq_div_pipe.
// Throughput: one item per cycle; each stage holds under backpressure.
// Depth is set by the 16 bit square root (4 stages) and 17 bit divider (3).
// Reset: synchronous rst clears every stage valid bit; payload is not reset.
module rotation_matrix_to_quaternion_unit (
  input  logic      clk,
  input  logic      rst,
  rmq_in_if.sink    in_ch,
  rmq_out_if.source out_ch
);
  import rmq_pkg::*;

  // Front stage: trace, root arguments, differences
  logic      vf, rdy_f;
  rmq_root_t df, df_next;
  logic      root_in_ready, root_out_valid;
  rmq_root_t root_out;
  // Path stage
  logic      vp, rdy_p;
  rmq_div_t  dp, dp_next;
  logic      div_in_ready, div_out_valid;
  rmq_div_t  div_out;
  // Output stage
  logic                  vo, rdy_o;
  logic [QW_W-1:0]       qw;
  logic signed [Q_W-1:0] qx, qy, qz, qx_next, qy_next, qz_next;

  logic signed [SUM_W-1:0]  sum;
  logic [ABS_W-1:0]         sum_abs;
  logic signed [DIAG_W-1:0] t0, t1, t2;
  logic [QW_W-1:0]          w;
  logic [DIFF_W-1:0]        mag [3];

  assign rdy_o = ~vo | out_ch.ready;
  assign rdy_p = ~vp | div_in_ready;
  assign rdy_f = ~vf | root_in_ready;
  assign in_ch.ready = rdy_f;

  // Front stage logic
  always_comb begin
    sum = SUM_W'(in_ch.m00) + SUM_W'(in_ch.m11) + SUM_W'(in_ch.m22)
        + SUM_W'(1 << FRACTION_BITS);
    sum_abs = sum[SUM_W-1] ? ABS_W'(-sum) : ABS_W'(sum);
    t0 = DIAG_W'(in_ch.m00) + DIAG_W'(1 << FRACTION_BITS);
    t1 = DIAG_W'(in_ch.m11) + DIAG_W'(1 << FRACTION_BITS);
    t2 = DIAG_W'(in_ch.m22) + DIAG_W'(1 << FRACTION_BITS);
    df_next = '0;
    df_next.lane[0].rem = SQ_W'(sum_abs) << FRACTION_BITS;
    df_next.lane[1].rem = (t0 > 0) ? SQ_W'(t0) << (FRACTION_BITS - 1) : '0;
    df_next.lane[2].rem = (t1 > 0) ? SQ_W'(t1) << (FRACTION_BITS - 1) : '0;
    df_next.lane[3].rem = (t2 > 0) ? SQ_W'(t2) << (FRACTION_BITS - 1) : '0;
    df_next.side.dx  = DIFF_W'(in_ch.m21) - DIFF_W'(in_ch.m12);
    df_next.side.dy  = DIFF_W'(in_ch.m02) - DIFF_W'(in_ch.m20);
    df_next.side.dz  = DIFF_W'(in_ch.m10) - DIFF_W'(in_ch.m01);
    df_next.side.n01 = in_ch.m01[IN_W-1];
    df_next.side.n02 = in_ch.m02[IN_W-1];
    df_next.side.n12 = in_ch.m12[IN_W-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vf <= 1'b0;
    end else if (rdy_f) begin
      vf <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_f) begin
      df <= df_next;
    end
  end

  rmq_root_pipe u_root (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vf),
    .in_ready  (root_in_ready),
    .in_data   (df),
    .out_valid (root_out_valid),
    .out_ready (rdy_p),
    .out_data  (root_out)
  );

  // Path stage: w, path choice, divider setup
  always_comb begin
    w = QW_W'(root_out.lane[0].root >> 1);
    mag[0] = root_out.side.dx[DIFF_W-1] ? -root_out.side.dx : root_out.side.dx;
    mag[1] = root_out.side.dy[DIFF_W-1] ? -root_out.side.dy : root_out.side.dy;
    mag[2] = root_out.side.dz[DIFF_W-1] ? -root_out.side.dz : root_out.side.dz;
    dp_next = '0;
    dp_next.dv   = {w, 2'b00};
    dp_next.qw   = w;
    dp_next.divp = (w >= QW_W'(W_MIN));
    dp_next.dgx  = QW_W'(root_out.lane[1].root);
    dp_next.dgy  = QW_W'(root_out.lane[2].root);
    dp_next.dgz  = QW_W'(root_out.lane[3].root);
    dp_next.n01  = root_out.side.n01;
    dp_next.n02  = root_out.side.n02;
    dp_next.n12  = root_out.side.n12;
    dp_next.lane[0].neg = root_out.side.dx[DIFF_W-1];
    dp_next.lane[1].neg = root_out.side.dy[DIFF_W-1];
    dp_next.lane[2].neg = root_out.side.dz[DIFF_W-1];
    for (int l = 0; l < 3; l++) begin
      dp_next.lane[l].rem = DIV_W'(mag[l]) << FRACTION_BITS;
      dp_next.lane[l].ovf = (DIV_W'(mag[l]) << FRACTION_BITS)
                         >= (DIV_W'({w, 2'b00}) << QUO_W);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= 1'b0;
    end else if (rdy_p) begin
      vp <= root_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_p) begin
      dp <= dp_next;
    end
  end

  rmq_div_pipe u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vp),
    .in_ready  (div_in_ready),
    .in_data   (dp),
    .out_valid (div_out_valid),
    .out_ready (rdy_o),
    .out_data  (div_out)
  );

  // Output stage: path select, sign choice, saturation
  always_comb begin
    if (div_out.divp) begin
      qx_next = sat_quo(div_out.lane[0]);
      qy_next = sat_quo(div_out.lane[1]);
      qz_next = sat_quo(div_out.lane[2]);
    end else if (div_out.dgx >= QW_W'(SIGN_MIN)) begin
      qx_next = apply_sign(div_out.dgx, 1'b0);
      qy_next = apply_sign(div_out.dgy, div_out.n01);
      qz_next = apply_sign(div_out.dgz, div_out.n02);
    end else if (div_out.dgy >= QW_W'(SIGN_MIN)) begin
      qx_next = apply_sign(div_out.dgx, div_out.n01);
      qy_next = apply_sign(div_out.dgy, 1'b0);
      qz_next = apply_sign(div_out.dgz, div_out.n12);
    end else if (div_out.dgz >= QW_W'(SIGN_MIN)) begin
      qx_next = apply_sign(div_out.dgx, div_out.n02);
      qy_next = apply_sign(div_out.dgy, div_out.n12);
      qz_next = apply_sign(div_out.dgz, 1'b0);
    end else begin
      qx_next = apply_sign(div_out.dgx, 1'b0);
      qy_next = apply_sign(div_out.dgy, 1'b0);
      qz_next = apply_sign(div_out.dgz, 1'b0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vo <= 1'b0;
    end else if (rdy_o) begin
      vo <= div_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o) begin
      qw <= div_out.qw;
      qx <= qx_next;
      qy <= qy_next;
      qz <= qz_next;
    end
  end

  assign out_ch.valid = vo;
  assign out_ch.qw    = qw;
  assign out_ch.qx    = qx;
  assign out_ch.qy    = qy;
  assign out_ch.qz    = qz;

  // Checks
  a_front_fill: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> vf)
    else $error("accepted item did not reach front stage");

  a_front_hold: assert property (@(posedge clk) disable iff (rst)
    (vf && !root_in_ready) |=> (vf && $stable(df)))
    else $error("front stage changed while stalled");

  a_divisor: assert property (@(posedge clk) disable iff (rst)
    vp |-> (dp.dv == {dp.qw, 2'b00}))
    else $error("divisor does not match w");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (vo && !out_ch.ready) |=> (vo && $stable(qx) && $stable(qw)))
    else $error("result changed while stalled");

endmodule

// ----- hw/rtl/rmq_root_pipe.sv -----
// Four stage pipelined floor square root, four lanes in parallel,
// four result bits per stage. Depends on rmq_pkg.
module rmq_root_pipe (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  rmq_pkg::rmq_root_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rmq_pkg::rmq_root_t  out_data
);
  import rmq_pkg::*;

  logic [ROOT_STAGES:0] vsrc;
  logic [ROOT_STAGES:0] rdy;
  rmq_root_t            src [ROOT_STAGES+1];
  rmq_root_t            nxt [ROOT_STAGES];
  logic [ROOT_STAGES-1:0] vld;
  rmq_root_t            dat [ROOT_STAGES];

  assign vsrc[0]          = in_valid;
  assign src[0]           = in_data;
  assign rdy[ROOT_STAGES] = out_ready;

  for (genvar s = 0; s < ROOT_STAGES; s++) begin : g_stage
    assign vsrc[s+1] = vld[s];
    assign src[s+1]  = dat[s];
    assign rdy[s]    = ~vld[s] | rdy[s+1];

    // Four square root bits on every lane
    always_comb begin
      nxt[s] = src[s];
      for (int j = 0; j < ROOT_PER; j++) begin
        for (int l = 0; l < 4; l++) begin
          nxt[s].lane[l] = sq_step(nxt[s].lane[l], ROOT_STEPS - 1 - s * ROOT_PER - j);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (rdy[s]) begin
        vld[s] <= vsrc[s];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[s]) begin
        dat[s] <= nxt[s];
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld[ROOT_STAGES-1];
  assign out_data  = dat[ROOT_STAGES-1];

endmodule

// ----- hw/rtl/rmq_div_pipe.sv -----
// Three stage pipelined restoring divider, three lanes sharing one
// divisor, up to six quotient bits per stage. Depends on rmq_pkg.
module rmq_div_pipe (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  rmq_pkg::rmq_div_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rmq_pkg::rmq_div_t  out_data
);
  import rmq_pkg::*;

  logic [DIV_STAGES:0]   vsrc;
  logic [DIV_STAGES:0]   rdy;
  rmq_div_t              src [DIV_STAGES+1];
  rmq_div_t              nxt [DIV_STAGES];
  logic [DIV_STAGES-1:0] vld;
  rmq_div_t              dat [DIV_STAGES];

  assign vsrc[0]         = in_valid;
  assign src[0]          = in_data;
  assign rdy[DIV_STAGES] = out_ready;

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    assign vsrc[s+1] = vld[s];
    assign src[s+1]  = dat[s];
    assign rdy[s]    = ~vld[s] | rdy[s+1];

    // Quotient bits for this stage; the last stage has fewer
    always_comb begin
      nxt[s] = src[s];
      for (int j = 0; j < DIV_PER; j++) begin
        if (DIV_STEPS - 1 - s * DIV_PER - j >= 0) begin
          for (int l = 0; l < 3; l++) begin
            nxt[s].lane[l] = div_step(nxt[s].lane[l], src[s].dv,
                                      DIV_STEPS - 1 - s * DIV_PER - j);
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (rdy[s]) begin
        vld[s] <= vsrc[s];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[s]) begin
        dat[s] <= nxt[s];
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld[DIV_STAGES-1];
  assign out_data  = dat[DIV_STAGES-1];

endmodule

// ----- tb/sv/rmq_tb_if.sv -----
`timescale 1ns / 100ps
// Testbench-side notes: the channel interfaces come from hw/rtl/rmq_if.sv.
// This file holds the helper package of the testbench. Depends on rmq_pkg.
package rmq_tb_pkg;
  import rmq_pkg::*;

  typedef struct {
    logic signed [IN_W-1:0] m [9];
  } matrix_t;

  typedef struct {
    logic [QW_W-1:0]       qw;
    logic signed [Q_W-1:0] qx, qy, qz;
  } quat_t;
endpackage

// ----- tb/sv/rotation_matrix_to_quaternion_unit_tb.sv -----
`timescale 1ns / 100ps
// Testbench for rotation_matrix_to_quaternion_unit: directed and random
// matrices, random gaps on both channels, results checked against an
// in-bench fixed point predictor. Depends on rmq_pkg, rmq_if, rmq_tb_pkg.
module rotation_matrix_to_quaternion_unit_tb;
  import rmq_pkg::*;
  import rmq_tb_pkg::*;

  localparam int ONE       = 1 << FRACTION_BITS;
  localparam int IDLE_LIM  = 20000;
  localparam int DRAIN_CYC = 30;

  logic clk;
  logic rst;
  rmq_in_if  in_ch ();
  rmq_out_if out_ch ();

  rotation_matrix_to_quaternion_unit u_dut (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  quat_t       quat_queue[$];
  int          n_fail;
  int          n_sent;
  int          n_got;
  int          n_divpath;
  int          idle_cnt;
  bit          stall_on = 1'b1;
  bit          in_busy;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Floor square root of a 64 bit value
  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n  -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint scaled_div(longint d, longint unsigned w);
    longint unsigned mag, q;
    mag = (d < 0) ? -d : d;
    q   = (mag << FRACTION_BITS) / (4 * w);
    if (q > 65536) q = 65536;
    return clamp16(d < 0 ? -longint'(q) : longint'(q));
  endfunction

  function automatic longint diag_mag(longint m);
    longint          t;
    longint unsigned r;
    t = m + ONE;
    if (t <= 0) return 0;
    r = floor_sqrt(longint'(t) << (FRACTION_BITS - 1));
    return (r > 32767) ? 32767 : r;
  endfunction

  function automatic bit signs_from(longint c);
    return c * 10000 > ONE;
  endfunction

  // Expected quaternion for one matrix
  function automatic quat_t matrix_to_quat(matrix_t mt);
    longint          m [9];
    longint          s, x, y, z;
    longint unsigned a, w;
    quat_t           q;
    foreach (m[i]) m[i] = mt.m[i];
    s = m[0] + m[4] + m[8] + ONE;
    a = (s < 0) ? -s : s;
    w = floor_sqrt(a << FRACTION_BITS) >> 1;
    if (w * 1000 > ONE) begin
      x = scaled_div(m[7] - m[5], w);
      y = scaled_div(m[2] - m[6], w);
      z = scaled_div(m[3] - m[1], w);
    end else begin
      x = diag_mag(m[0]);
      y = diag_mag(m[4]);
      z = diag_mag(m[8]);
      if (signs_from(x)) begin
        if (m[1] < 0) y = -y;
        if (m[2] < 0) z = -z;
      end else if (signs_from(y)) begin
        if (m[1] < 0) x = -x;
        if (m[5] < 0) z = -z;
      end else if (signs_from(z)) begin
        if (m[5] < 0) y = -y;
        if (m[2] < 0) x = -x;
      end
    end
    q.qw = (w > 32767) ? 15'h7fff : QW_W'(w);
    q.qx = Q_W'(x);
    q.qy = Q_W'(y);
    q.qz = Q_W'(z);
    return q;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Drop valid once after the last accepted item
  task automatic idle_input();
    if (in_busy) begin
      in_ch.valid <= 1'b0;
      in_busy = 1'b0;
    end
  endtask

  // Send one matrix, hold until accepted; valid stays high for back to back
  task automatic send_matrix(matrix_t mt);
    int              g;
    longint          s;
    longint unsigned a;
    g = gap_len();
    if (g > 0) begin
      idle_input();
      repeat (g) @(posedge clk);
    end
    quat_queue.push_back(matrix_to_quat(mt));
    s = longint'(mt.m[0]) + mt.m[4] + mt.m[8] + ONE;
    a = (s < 0) ? -s : s;
    in_ch.valid <= 1'b1;
    in_busy = 1'b1;
    in_ch.m00 <= mt.m[0]; in_ch.m01 <= mt.m[1]; in_ch.m02 <= mt.m[2];
    in_ch.m10 <= mt.m[3]; in_ch.m11 <= mt.m[4]; in_ch.m12 <= mt.m[5];
    in_ch.m20 <= mt.m[6]; in_ch.m21 <= mt.m[7]; in_ch.m22 <= mt.m[8];
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    n_sent++;
    if ((floor_sqrt(a << FRACTION_BITS) >> 1) * 1000 > ONE) n_divpath++;
  endtask

  function automatic logic signed [IN_W-1:0] rand_elem();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return IN_W'($urandom);
    if (r == 1) return ($urandom_range(0, 1) == 1) ? IN_W'(ONE) : IN_W'(-ONE);
    return IN_W'($urandom_range(0, 2 * ONE) - ONE);
  endfunction

  // Random rotation-like matrix: axis-angle with integer approximations
  function automatic matrix_t rand_rotation();
    matrix_t mt;
    real     ang, ux, uy, uz, n, c, s, t, v [9];
    ux = $urandom_range(0, 2000) - 1000.0;
    uy = $urandom_range(0, 2000) - 1000.0;
    uz = $urandom_range(0, 2000) - 1000.0;
    n  = $sqrt(ux * ux + uy * uy + uz * uz) + 1e-9;
    ux /= n; uy /= n; uz /= n;
    ang = $urandom_range(0, 62832) / 10000.0;
    if ($urandom_range(0, 5) == 0) ang = 3.14159265 + ($urandom_range(0, 200) - 100) / 1.0e5;
    c = $cos(ang); s = $sin(ang); t = 1.0 - c;
    v[0] = t*ux*ux + c;    v[1] = t*ux*uy - s*uz; v[2] = t*ux*uz + s*uy;
    v[3] = t*ux*uy + s*uz; v[4] = t*uy*uy + c;    v[5] = t*uy*uz - s*ux;
    v[6] = t*ux*uz - s*uy; v[7] = t*uy*uz + s*ux; v[8] = t*uz*uz + c;
    foreach (v[i]) mt.m[i] = IN_W'($rtoi(v[i] * ONE) + $urandom_range(0, 4) - 2);
    return mt;
  endfunction

  function automatic matrix_t mk(int a0, int a1, int a2, int a3, int a4,
                                 int a5, int a6, int a7, int a8);
    matrix_t mt;
    mt.m[0] = IN_W'(a0); mt.m[1] = IN_W'(a1); mt.m[2] = IN_W'(a2);
    mt.m[3] = IN_W'(a3); mt.m[4] = IN_W'(a4); mt.m[5] = IN_W'(a5);
    mt.m[6] = IN_W'(a6); mt.m[7] = IN_W'(a7); mt.m[8] = IN_W'(a8);
    return mt;
  endfunction

  // Identity, 180 degree turns about each axis, extremes, sign cases
  task automatic test_directed();
    send_matrix(mk(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE));
    send_matrix(mk(ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE));
    send_matrix(mk(-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE));
    send_matrix(mk(-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE));
    send_matrix(mk(-ONE, -5, -7, 3, -ONE, -9, 2, 4, -ONE));
    send_matrix(mk(ONE, -100, -200, 0, -ONE, 0, 0, 0, -ONE));
    send_matrix(mk(-ONE, -100, 0, 0, ONE, -300, 0, 0, -ONE));
    send_matrix(mk(-ONE, 0, -50, 0, -ONE, -60, 0, 0, ONE));
    send_matrix(mk(-ONE, ONE, -ONE, -ONE, -ONE, ONE, ONE, -ONE, -ONE));
    send_matrix(mk(ONE, ONE, ONE, -ONE, ONE, -ONE, ONE, ONE, -ONE));
    send_matrix(mk(-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768));
    send_matrix(mk(32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767));
    send_matrix(mk(-5461, ONE, -ONE, -ONE, -5461, ONE, ONE, -ONE, -5462));
    send_matrix(mk(-5460, ONE, -ONE, -ONE, -5461, ONE, ONE, -ONE, -5461));
    send_matrix(mk(-ONE - 1, 0, 0, 0, -ONE + 1, 0, 0, 0, -ONE + 1));
    send_matrix(mk(-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE));
    send_matrix(mk(-ONE + 1, -1, -1, 0, -ONE, -1, 0, 0, -ONE));
    send_matrix(mk(0, -ONE, 0, ONE, 0, 0, 0, 0, ONE));
    send_matrix(mk(-1, -1, -1, -1, -1, -1, -1, -1, -1));
    send_matrix(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
  endtask

  // Mostly near-rotations, some fully random words
  task automatic test_random(int count);
    matrix_t mt;
    repeat (count) begin
      if ($urandom_range(0, 3) == 0) begin
        foreach (mt.m[i]) mt.m[i] = rand_elem();
      end else begin
        mt = rand_rotation();
      end
      send_matrix(mt);
    end
  endtask

  // Sender holds off until the pipe has drained
  task automatic test_drain_pause();
    idle_input();
    while (quat_queue.size() != 0) @(posedge clk);
    test_random(30);
  endtask

  // Receiver stalls and result check
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= stall_on ? ($urandom_range(0, 9) > 3) : 1'b1;
      if (out_ch.valid && out_ch.ready) begin
        if (quat_queue.size() == 0) begin
          $error("result with nothing expected");
          n_fail++;
        end else begin
          quat_t e;
          e = quat_queue.pop_front();
          n_got++;
          if (out_ch.qw !== e.qw) begin
            $error("qw expected %0d got %0d", e.qw, out_ch.qw); n_fail++;
          end
          if (out_ch.qx !== e.qx) begin
            $error("qx expected %0d got %0d", e.qx, out_ch.qx); n_fail++;
          end
          if (out_ch.qy !== e.qy) begin
            $error("qy expected %0d got %0d", e.qy, out_ch.qy); n_fail++;
          end
          if (out_ch.qz !== e.qz) begin
            $error("qz expected %0d got %0d", e.qz, out_ch.qz); n_fail++;
          end
        end
      end
    end
  end

  // Toggle receiver stall mode now and then
  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_on <= ~stall_on;
  end

  // Watchdog on cycles with no handshake
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= IDLE_LIM) begin
      $display("timeout with %0d results outstanding", quat_queue.size());
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  initial begin
    int wait_cyc;
    n_fail = 0; n_sent = 0; n_got = 0; n_divpath = 0;
    in_busy = 1'b0;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    {in_ch.m00, in_ch.m01, in_ch.m02, in_ch.m10, in_ch.m11} = '0;
    {in_ch.m12, in_ch.m20, in_ch.m21, in_ch.m22} = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(800);
    test_drain_pause();
    test_random(800);
    idle_input();
    wait_cyc = 0;
    while (quat_queue.size() != 0 && wait_cyc < 100000) begin
      @(posedge clk);
      wait_cyc++;
    end
    repeat (DRAIN_CYC) @(posedge clk);
    if (quat_queue.size() != 0) begin
      $error("%0d results never arrived", quat_queue.size());
      n_fail++;
    end
    $display("Sent %0d matrices (directed, near-rotation, raw words), %0d results checked",
             n_sent, n_got);
    $display("%0d took the division path; random gaps and output stalls; %0d mismatches",
             n_divpath, n_fail);
    if (n_fail == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
